@@ src/twfra_pkg.sv @@
// Shared constants, widths and interface structs for the three-window free-ratio averager.
package twfra_pkg;

   // Field widths of the stream payloads
   localparam int AMT_W    = 40;              // available / total amount
   localparam int PCT_W    = 15;              // percentage, 8 fraction bits
   localparam int PCT_FULL = 25600;           // 100.0 in 7.8 fixed point

   // Window depths in samples
   localparam int SHORT_DEPTH = 2;
   localparam int MID_DEPTH   = 120;
   localparam int LONG_DEPTH  = 240;

   // Dividend of the percentage: available * 25600 needs 40 + 15 bits
   localparam int PROD_W   = AMT_W + PCT_W;
   localparam int HUND_W   = AMT_W + 7;       // available * 100
   localparam int QCNT_W   = $clog2(PCT_W + 1);

   // Running sums hold at most depth * 100.0
   localparam int SHORT_SUM_W = $clog2(SHORT_DEPTH * PCT_FULL + 1);
   localparam int MID_SUM_W   = $clog2(MID_DEPTH * PCT_FULL + 1);
   localparam int LONG_SUM_W  = $clog2(LONG_DEPTH * PCT_FULL + 1);

   localparam int SHORT_POS_W = (SHORT_DEPTH > 1) ? $clog2(SHORT_DEPTH) : 1;
   localparam int MID_POS_W   = (MID_DEPTH > 1)   ? $clog2(MID_DEPTH)   : 1;
   localparam int LONG_POS_W  = (LONG_DEPTH > 1)  ? $clog2(LONG_DEPTH)  : 1;

   // Window means by reciprocal multiplication: floor(sum / depth) = (sum * rcp) >> sh
   // with rcp = ceil(2^sh / depth); exact for every sum below 2^SUM_W
   localparam int SHORT_RCP_SH = SHORT_SUM_W + SHORT_POS_W;
   localparam int MID_RCP_SH   = MID_SUM_W + MID_POS_W;
   localparam int LONG_RCP_SH  = LONG_SUM_W + LONG_POS_W;
   localparam longint unsigned SHORT_RCP =
      ((64'd1 << SHORT_RCP_SH) + SHORT_DEPTH - 1) / SHORT_DEPTH;
   localparam longint unsigned MID_RCP =
      ((64'd1 << MID_RCP_SH) + MID_DEPTH - 1) / MID_DEPTH;
   localparam longint unsigned LONG_RCP =
      ((64'd1 << LONG_RCP_SH) + LONG_DEPTH - 1) / LONG_DEPTH;

   localparam int MEAN_OP_W   = (LONG_SUM_W > MID_SUM_W)
                              ? ((LONG_SUM_W > SHORT_SUM_W) ? LONG_SUM_W : SHORT_SUM_W)
                              : ((MID_SUM_W > SHORT_SUM_W) ? MID_SUM_W : SHORT_SUM_W);
   localparam int RCP_W       = MEAN_OP_W + 2;
   localparam int MEAN_PROD_W = MEAN_OP_W + RCP_W;

   // Stream payload widths (both already whole bytes)
   localparam int REQ_DATA_W = 2 * AMT_W;
   localparam int RSP_DATA_W = 3 * (PCT_W + 1);

   // Window selector codes
   localparam int WIN_NUM   = 3;
   localparam int WIN_IDX_W = 2;
   localparam logic [WIN_IDX_W-1:0] WIN_SHORT = 2'd0;
   localparam logic [WIN_IDX_W-1:0] WIN_MID   = 2'd1;
   localparam logic [WIN_IDX_W-1:0] WIN_LONG  = 2'd2;

   typedef struct packed {
      logic rd;   // fetch the oldest entry of every window
      logic wr;   // push the new percentage, update sums and positions
   } win_ctl_type;

   typedef struct packed {
      logic [SHORT_SUM_W-1:0] short_sum;
      logic [MID_SUM_W-1:0]   mid_sum;
      logic [LONG_SUM_W-1:0]  long_sum;
      logic                   short_full;
      logic                   mid_full;
      logic                   long_full;
   } win_sts_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [AMT_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [PCT_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ src/twfra_ram.sv @@
// Generic single-port RAM with registered read data.
module twfra_ram #(
   parameter int DEPTH  = 2,
   parameter int WIDTH  = 15,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wr_data,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/twfra_div.sv @@
// Restoring divider, one quotient bit per cycle, 15-bit quotient.
module twfra_div
   import twfra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [AMT_W-1:0]  rem_ff, rem_in;
   logic [PCT_W-1:0]  num_ff, num_in;     // dividend low bits out, quotient bits in
   logic [AMT_W-1:0]  divisor_ff, divisor_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [AMT_W:0]    partial;
   logic [AMT_W:0]    diff;
   logic              ge;

   // Trial subtract of the divisor from the shifted partial remainder
   assign partial = {rem_ff, num_ff[PCT_W-1]};
   assign ge      = partial >= {1'b0, divisor_ff};
   assign diff    = partial - {1'b0, divisor_ff};

   always_comb begin
      rem_in     = rem_ff;
      num_in     = num_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         // caller guarantees dividend >> 15 < divisor, so 15 bits of quotient suffice
         rem_in     = div_req.dividend[PROD_W-1:PCT_W];
         num_in     = div_req.dividend[PCT_W-1:0];
         divisor_in = div_req.divisor;
         cnt_in     = QCNT_W'(PCT_W);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[AMT_W-1:0] : partial[AMT_W-1:0];
         num_in  = {num_ff[PCT_W-2:0], ge};
         cnt_in  = cnt_ff - QCNT_W'(1);
         busy_in = (cnt_ff != QCNT_W'(1));
         done_in = (cnt_ff == QCNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff     <= rem_in;
      num_ff     <= num_in;
      divisor_ff <= divisor_in;
      cnt_ff     <= cnt_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = num_ff;

   // Partial remainder stays below the divisor throughout a division
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < divisor_ff))
      else $error("divider remainder out of range");

   // Done pulses once, after the unit has gone idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!busy_ff && !$past(done_ff)))
      else $error("divider done while busy or repeated");

   // No new division is started on top of one in flight
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider restarted while busy");

endmodule

@@ src/twfra_windows.sv @@
// Three ring windows with running sums, write positions and full flags.
module twfra_windows
   import twfra_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  win_ctl_type      win_ctl,
   input  logic [PCT_W-1:0] pct,
   output win_sts_type      win_sts
);

   logic [SHORT_POS_W-1:0] short_pos_ff, short_pos_in;
   logic [MID_POS_W-1:0]   mid_pos_ff, mid_pos_in;
   logic [LONG_POS_W-1:0]  long_pos_ff, long_pos_in;
   logic [SHORT_SUM_W-1:0] short_sum_ff, short_sum_in;
   logic [MID_SUM_W-1:0]   mid_sum_ff, mid_sum_in;
   logic [LONG_SUM_W-1:0]  long_sum_ff, long_sum_in;
   logic                   short_full_ff, short_full_in;
   logic                   mid_full_ff, mid_full_in;
   logic                   long_full_ff, long_full_in;

   logic [PCT_W-1:0] short_old, mid_old, long_old;

   twfra_ram #(.DEPTH(SHORT_DEPTH), .WIDTH(PCT_W)) u_short_ram (
      .clock   (clock),
      .wr_en   (win_ctl.wr),
      .rd_en   (win_ctl.rd),
      .addr    (short_pos_ff),
      .wr_data (pct),
      .rd_data (short_old)
   );

   twfra_ram #(.DEPTH(MID_DEPTH), .WIDTH(PCT_W)) u_mid_ram (
      .clock   (clock),
      .wr_en   (win_ctl.wr),
      .rd_en   (win_ctl.rd),
      .addr    (mid_pos_ff),
      .wr_data (pct),
      .rd_data (mid_old)
   );

   twfra_ram #(.DEPTH(LONG_DEPTH), .WIDTH(PCT_W)) u_long_ram (
      .clock   (clock),
      .wr_en   (win_ctl.wr),
      .rd_en   (win_ctl.rd),
      .addr    (long_pos_ff),
      .wr_data (pct),
      .rd_data (long_old)
   );

   // Oldest entry only leaves the sum once the window has wrapped
   always_comb begin
      short_pos_in  = short_pos_ff;
      mid_pos_in    = mid_pos_ff;
      long_pos_in   = long_pos_ff;
      short_sum_in  = short_sum_ff;
      mid_sum_in    = mid_sum_ff;
      long_sum_in   = long_sum_ff;
      short_full_in = short_full_ff;
      mid_full_in   = mid_full_ff;
      long_full_in  = long_full_ff;
      if (win_ctl.wr) begin
         short_sum_in = short_sum_ff
                      - (short_full_ff ? SHORT_SUM_W'(short_old) : '0)
                      + SHORT_SUM_W'(pct);
         mid_sum_in   = mid_sum_ff
                      - (mid_full_ff ? MID_SUM_W'(mid_old) : '0)
                      + MID_SUM_W'(pct);
         long_sum_in  = long_sum_ff
                      - (long_full_ff ? LONG_SUM_W'(long_old) : '0)
                      + LONG_SUM_W'(pct);

         if (short_pos_ff == SHORT_POS_W'(SHORT_DEPTH - 1)) begin
            short_pos_in  = '0;
            short_full_in = 1'b1;
         end else begin
            short_pos_in  = short_pos_ff + SHORT_POS_W'(1);
         end
         if (mid_pos_ff == MID_POS_W'(MID_DEPTH - 1)) begin
            mid_pos_in  = '0;
            mid_full_in = 1'b1;
         end else begin
            mid_pos_in  = mid_pos_ff + MID_POS_W'(1);
         end
         if (long_pos_ff == LONG_POS_W'(LONG_DEPTH - 1)) begin
            long_pos_in  = '0;
            long_full_in = 1'b1;
         end else begin
            long_pos_in  = long_pos_ff + LONG_POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_pos_ff  <= '0;
         mid_pos_ff    <= '0;
         long_pos_ff   <= '0;
         short_sum_ff  <= '0;
         mid_sum_ff    <= '0;
         long_sum_ff   <= '0;
         short_full_ff <= 1'b0;
         mid_full_ff   <= 1'b0;
         long_full_ff  <= 1'b0;
      end else begin
         short_pos_ff  <= short_pos_in;
         mid_pos_ff    <= mid_pos_in;
         long_pos_ff   <= long_pos_in;
         short_sum_ff  <= short_sum_in;
         mid_sum_ff    <= mid_sum_in;
         long_sum_ff   <= long_sum_in;
         short_full_ff <= short_full_in;
         mid_full_ff   <= mid_full_in;
         long_full_ff  <= long_full_in;
      end
   end

   assign win_sts.short_sum  = short_sum_ff;
   assign win_sts.mid_sum    = mid_sum_ff;
   assign win_sts.long_sum   = long_sum_ff;
   assign win_sts.short_full = short_full_ff;
   assign win_sts.mid_full   = mid_full_ff;
   assign win_sts.long_full  = long_full_ff;

endmodule

@@ src/three_window_free_ratio_average_core.sv @@
// Top level: sequencer around the divider and the three ring windows.
// Sequence: accept, scale, percent division, ring read and push, then one mean per cycle
//    on the reciprocal multiplier, then rsp_tvalid; a saturated transaction skips the
//    division, a bad one skips the division and the ring read and push.
// Flow: a request is taken once the last result is registered; the restoring divider,
//    one quotient bit per cycle, is the slowest. An untaken response holds the sequencer.
// Reset: synchronous, active high; clears sequencer, sums, positions and full flags.
//    Ring stores are not cleared: an entry read before the window has wrapped is ignored.
module three_window_free_ratio_average_core
   import twfra_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // available_amount[39:0], total_amount[79:40]
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // short_mean[14:0], short_valid[15],
                                              // mid_mean[30:16], mid_valid[31],
                                              // long_mean[46:32], long_valid[47]
   output logic                  rsp_tuser    // bad_sample[0]
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_PCT_GO,
      ST_PCT_WAIT,
      ST_RING_RD,
      ST_RING_UPD,
      ST_MEAN,
      ST_OUT
   } state_type;

   state_type              state_ff, state_in;
   logic [WIN_IDX_W-1:0]   idx_ff, idx_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;

   logic [AMT_W-1:0]       avail_ff, avail_in;
   logic [AMT_W-1:0]       total_ff, total_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [PCT_W-1:0]       pct_ff, pct_in;
   logic                   bad_ff, bad_in;
   logic [PCT_W-1:0]       mean_ff [WIN_NUM];
   logic [PCT_W-1:0]       mean_in [WIN_NUM];
   logic [RSP_DATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;
   logic                   rsp_tuser_ff, rsp_tuser_in;

   logic                   req_accept;
   logic                   out_free;
   logic [HUND_W-1:0]      hundred_x;

   logic [MEAN_OP_W-1:0]   mean_op;
   logic [RCP_W-1:0]       mean_rcp;
   logic [MEAN_PROD_W-1:0] mean_prod;
   logic [PCT_W-1:0]       mean_q;

   div_req_type            div_req;
   div_rsp_type            div_rsp;
   win_ctl_type            win_ctl;
   win_sts_type            win_sts;

   twfra_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   twfra_windows u_windows (
      .clock   (clock),
      .reset   (reset),
      .win_ctl (win_ctl),
      .pct     (pct_ff),
      .win_sts (win_sts)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   // output register frees as its transaction is taken
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // 25600 * a = (64 + 32 + 4) * a << 8: shift-add, no multiplier
   assign hundred_x = HUND_W'({avail_ff, 6'b0}) + HUND_W'({avail_ff, 5'b0})
                    + HUND_W'({avail_ff, 2'b0});
   assign prod_in   = {hundred_x, 8'b0};

   // Shared reciprocal multiplier: one window mean per cycle, selected by idx
   always_comb begin
      unique case (idx_ff)
         WIN_MID: begin
            mean_op  = MEAN_OP_W'(win_sts.mid_sum);
            mean_rcp = RCP_W'(MID_RCP);
         end
         WIN_LONG: begin
            mean_op  = MEAN_OP_W'(win_sts.long_sum);
            mean_rcp = RCP_W'(LONG_RCP);
         end
         default: begin
            mean_op  = MEAN_OP_W'(win_sts.short_sum);
            mean_rcp = RCP_W'(SHORT_RCP);
         end
      endcase
      mean_prod = MEAN_PROD_W'(mean_op) * MEAN_PROD_W'(mean_rcp);
      unique case (idx_ff)
         WIN_MID:  mean_q = PCT_W'(mean_prod >> MID_RCP_SH);
         WIN_LONG: mean_q = PCT_W'(mean_prod >> LONG_RCP_SH);
         default:  mean_q = PCT_W'(mean_prod >> SHORT_RCP_SH);
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      avail_in      = avail_ff;
      total_in      = total_ff;
      pct_in        = pct_ff;
      bad_in        = bad_ff;
      mean_in       = mean_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      win_ctl       = '0;

      div_req.start    = 1'b0;
      div_req.dividend = prod_ff;
      div_req.divisor  = total_ff;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               avail_in = req_tdata[AMT_W-1:0];
               total_in = req_tdata[2*AMT_W-1:AMT_W];
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            bad_in = (total_ff == '0);
            idx_in = WIN_SHORT;
            if (total_ff == '0) begin
               // bad sample: nothing pushed, means show the state as it stands
               state_in = ST_MEAN;
            end else if (avail_ff >= total_ff) begin
               pct_in   = PCT_W'(PCT_FULL);
               state_in = ST_RING_RD;
            end else begin
               state_in = ST_PCT_GO;
            end
         end
         ST_PCT_GO: begin
            div_req.start = 1'b1;
            state_in      = ST_PCT_WAIT;
         end
         ST_PCT_WAIT: begin
            if (div_rsp.done) begin
               pct_in   = div_rsp.quotient;
               state_in = ST_RING_RD;
            end
         end
         ST_RING_RD: begin
            win_ctl.rd = 1'b1;
            state_in   = ST_RING_UPD;
         end
         ST_RING_UPD: begin
            win_ctl.wr = 1'b1;
            state_in   = ST_MEAN;
         end
         ST_MEAN: begin
            mean_in[idx_ff] = mean_q;
            if (idx_ff == WIN_LONG) begin
               state_in = ST_OUT;
            end else begin
               idx_in   = idx_ff + WIN_IDX_W'(1);
            end
         end
         ST_OUT: begin
            if (out_free) begin
               // a window that has not yet filled reports a zero mean
               rsp_tdata_in = {win_sts.long_full,
                               win_sts.long_full  ? mean_ff[WIN_LONG]  : PCT_W'(0),
                               win_sts.mid_full,
                               win_sts.mid_full   ? mean_ff[WIN_MID]   : PCT_W'(0),
                               win_sts.short_full,
                               win_sts.short_full ? mean_ff[WIN_SHORT] : PCT_W'(0)};
               rsp_tuser_in  = bad_ff;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= WIN_SHORT;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      avail_ff     <= avail_in;
      total_ff     <= total_in;
      prod_ff      <= prod_in;
      pct_ff       <= pct_in;
      bad_ff       <= bad_in;
      mean_ff      <= mean_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // Percent division only runs where the quotient is below 100.0
   a_pct_operands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PCT_GO) |-> (avail_ff < total_ff))
      else $error("percent division started with available >= total");

   // Percentage pushed into the windows never exceeds 100.0
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RING_RD) |-> (pct_ff <= PCT_W'(PCT_FULL)))
      else $error("percentage out of range at push");

   // Divider results only arrive while the sequencer waits for them
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_PCT_WAIT))
      else $error("divider result outside the wait state");

   // A bad transaction never touches the ring windows
   a_bad_no_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE && total_ff == '0) |=> (state_ff == ST_MEAN))
      else $error("bad transaction routed to a window push");

endmodule

@@ dv/tb_three_window_free_ratio_average_core.sv @@
// Self-checking testbench for the three-window free-ratio averaging core.
module tb_three_window_free_ratio_average_core
   import twfra_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Run control
   localparam int unsigned RANDOM_ITEMS  = 1085;     // after the directed part
   localparam int unsigned LONG_HOLD     = 800;      // receiver hold-off, in cycles
   localparam int unsigned HOLD_AT       = 300;      // results seen before the hold-off
   localparam int unsigned DRAIN_CYCLES  = 150;      // several times the core latency
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned FIELD_STRIDE  = PCT_W + 1;
   localparam logic [AMT_W-1:0] AMT_MAX  = {AMT_W{1'b1}};

   // Shapes of the random sample bursts
   typedef enum int {
      MIX_NOISE,      // both amounts unrelated
      MIX_FRACTION,   // available below total, anywhere in range
      MIX_SATURATE,   // available at or above total
      MIX_EMPTY,      // available tiny against total, percentage near zero
      MIX_FULL        // available just under total, percentage near 100.0
   } sample_mix_type;

   // One response as the core should deliver it
   typedef struct packed {
      logic [WIN_NUM-1:0][PCT_W-1:0] mean;
      logic [WIN_NUM-1:0]            full;
      logic                          bad;
   } window_report_type;

   // Mirror of the window state plus the queue of outstanding reports
   class window_scoreboard;
      logic [PCT_W-1:0]  ring[WIN_NUM][LONG_DEPTH];
      int unsigned       depth[WIN_NUM];
      int unsigned       sum[WIN_NUM];
      int unsigned       slot[WIN_NUM];
      bit                filled[WIN_NUM];
      window_report_type outstanding[$];
      string             win_label[WIN_NUM];
      int unsigned       errors;
      int unsigned       checked;
      int unsigned       bad_seen;
      int unsigned       saturated_seen;
      int unsigned       long_min;
      int unsigned       long_max;

      function new();
         depth[WIN_SHORT]     = SHORT_DEPTH;
         depth[WIN_MID]       = MID_DEPTH;
         depth[WIN_LONG]      = LONG_DEPTH;
         win_label[WIN_SHORT] = "short";
         win_label[WIN_MID]   = "mid";
         win_label[WIN_LONG]  = "long";
         long_min             = PCT_FULL;
      endfunction

      function int unsigned pending();
         return outstanding.size();
      endfunction

      // Predict the report for an accepted request transaction
      function void note_request(logic [AMT_W-1:0] avail, logic [AMT_W-1:0] total);
         logic [63:0]       scaled;
         logic [PCT_W-1:0]  pct;
         window_report_type rep;
         rep.bad = (total == '0);
         if (rep.bad) begin
            bad_seen++;
         end else begin
            if (avail >= total) begin
               pct = PCT_W'(PCT_FULL);
               saturated_seen++;
            end else begin
               scaled = 64'(avail) * 64'(PCT_FULL);
               pct    = PCT_W'(scaled / 64'(total));
            end
            // push into every ring; oldest entry leaves once the ring has wrapped
            for (int w = 0; w < WIN_NUM; w++) begin
               if (filled[w]) sum[w] -= ring[w][slot[w]];
               ring[w][slot[w]] = pct;
               sum[w] += pct;
               slot[w]++;
               if (slot[w] == depth[w]) begin
                  slot[w]   = 0;
                  filled[w] = 1'b1;
               end
            end
         end
         for (int w = 0; w < WIN_NUM; w++) begin
            rep.full[w] = filled[w];
            rep.mean[w] = filled[w] ? PCT_W'(sum[w] / depth[w]) : '0;
         end
         outstanding.push_back(rep);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      // Compare an accepted response with the oldest prediction
      function void check_response(logic [RSP_DATA_W-1:0] data, logic user);
         window_report_type want;
         if (outstanding.size() == 0) begin
            $error("response transaction with no request outstanding: data %h", data);
            errors++;
            return;
         end
         want = outstanding.pop_front();
         checked++;
         for (int w = 0; w < WIN_NUM; w++) begin
            compare_field({win_label[w], "_mean"}, want.mean[w],
                          data[w*FIELD_STRIDE +: PCT_W]);
            compare_field({win_label[w], "_valid"}, want.full[w],
                          data[w*FIELD_STRIDE + PCT_W]);
         end
         compare_field("bad_sample", want.bad, user);
         if (want.full[WIN_LONG]) begin
            if (want.mean[WIN_LONG] < long_min) long_min = want.mean[WIN_LONG];
            if (want.mean[WIN_LONG] > long_max) long_max = want.mean[WIN_LONG];
         end
      endfunction
   endclass

   // Clock, reset and stream signals; every input known from time zero
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // available_amount[39:0], total_amount[79:40]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // short_mean[14:0], short_valid[15],
                                            // mid_mean[30:16], mid_valid[31],
                                            // long_mean[46:32], long_valid[47]
   logic                  rsp_tuser;        // bad_sample[0]

   int unsigned           cycle_count = 0;
   window_scoreboard      sb = new();

   three_window_free_ratio_average_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Watchdog: a hung handshake ends the run here
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // Idle length: mostly none, often a few cycles, now and then a long stretch
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   // 40-bit amount of random magnitude, so small and huge values both turn up
   function automatic logic [AMT_W-1:0] rand_amount();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return AMT_W'(raw) >> $urandom_range(0, AMT_W - 1);
   endfunction

   // Offer one request transaction and hold it until the core takes it.
   // Valid stays high into the next transaction unless a gap is drawn.
   task automatic send_item(input logic [AMT_W-1:0] avail, input logic [AMT_W-1:0] total,
                            input bit quiet);
      int unsigned gap;
      req_tdata  <= {total, avail};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(avail, total);
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Sender idles until every outstanding response has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Response side: checks each transaction and throttles tready.
   // Once, after HOLD_AT results, it drops tready for the LONG_HOLD hold-off while the
   // sender keeps offering, so the core fills and backs up its request side.
   initial begin : response_sink
      int unsigned stall;
      int unsigned run;
      bit          held;
      stall = 0;
      run   = 0;
      held  = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
         if (!held && sb.checked == HOLD_AT) begin
            held  = 1'b1;
            stall = LONG_HOLD;
            run   = 0;
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (run > 0) begin
            run--;
            rsp_tready <= 1'b1;
         end else begin
            // next ready stretch: now and then a long one with no stalls at all
            run   = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                : $urandom_range(1, 8);
            stall = pick_gap();
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus: directed corner cases, then random bursts of shaped samples
   initial begin : stimulus
      logic [AMT_W-1:0] dir_avail[15];
      logic [AMT_W-1:0] dir_total[15];
      logic [AMT_W-1:0] avail;
      logic [AMT_W-1:0] total;
      sample_mix_type   mix;
      int unsigned      burst;
      int unsigned      sent;
      bit               quiet;
      bit               paused;

      // zero total before any push, then the percentage extremes and rounding,
      // then alternating bit patterns and a zero total with the rings part full
      dir_avail = '{40'd0, AMT_MAX, 40'd0, AMT_MAX, AMT_MAX, 40'd1, AMT_MAX - 1,
                    40'd1, 40'd1, 40'd2, 40'h55_5555_5555, 40'hAA_AAAA_AAAA,
                    40'd0, 40'd1, 40'd5};
      dir_total = '{40'd0, 40'd0, AMT_MAX, AMT_MAX, 40'd1, AMT_MAX, AMT_MAX,
                    40'd2, 40'd3, 40'd3, 40'hAA_AAAA_AAAA, AMT_MAX,
                    40'd1, 40'd1, 40'd0};
      sent   = 0;
      paused = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 15; i++) send_item(dir_avail[i], dir_total[i], 1'b0);
      wait_drained();

      while (sent < RANDOM_ITEMS) begin
         mix   = sample_mix_type'($urandom_range(0, 4));
         burst = $urandom_range(20, 300);
         quiet = ($urandom_range(0, 4) == 0);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            // sender pause halfway through: the core must go fully idle
            if (!paused && sent == RANDOM_ITEMS / 2) begin
               wait_drained();
               paused = 1'b1;
            end
            total = rand_amount();
            if (total == '0) total = 40'd1;
            case (mix)
               MIX_NOISE:    avail = rand_amount();
               MIX_FRACTION: avail = rand_amount() % total;
               MIX_SATURATE: avail = $urandom_range(0, 1) ? total : (total | rand_amount());
               MIX_EMPTY:    avail = rand_amount() % ((total >> 8) + 1);
               default:      avail = total - 1 - (rand_amount() % ((total >> 6) + 1));
            endcase
            // zero totals scattered at random through the bursts
            if ($urandom_range(0, 33) == 0) total = '0;
            send_item(avail, total, quiet);
            sent++;
         end
      end

      wait_drained();
      // any stray response after the last one lands in the sink as an error
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d responses never arrived", sb.pending());
         sb.errors++;
      end

      $display("covered %0d transactions: %0d zero-total, %0d saturated percentages",
               sb.checked, sb.bad_seen, sb.saturated_seen);
      $display("long window mean ranged %0d..%0d once full; %0d cycles",
               sb.long_min, sb.long_max, cycle_count);
      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
